// File: rtl/sdu_pkg.sv
// Package for the signed divide unit: widths, register offsets, FSM state type
// and the command/status structs between controller and datapath.
// No dependencies.
package sdu_pkg;

  localparam int DATA_W    = 32;
  localparam int DVD_W     = 64;
  localparam int IDX_W     = 3;
  localparam int CTRL_W    = 2;
  localparam int VEC_W     = 16;
  localparam int DIV_ITERS = 32;  // two quotient bits per iteration
  localparam int CNT_W     = 5;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [IDX_W-1:0] IDX_DIVISOR = 3'd0;
  localparam logic [IDX_W-1:0] IDX_SHORT   = 3'd1;
  localparam logic [IDX_W-1:0] IDX_CONTROL = 3'd2;
  localparam logic [IDX_W-1:0] IDX_VECTOR  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_HIGH    = 3'd4;
  localparam logic [IDX_W-1:0] IDX_LONG    = 3'd5;

  localparam int FLAG_BIT = 0;
  localparam int IE_BIT   = 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_ITERS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_DIVIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit_reg;
    logic commit_div;
  } dp_cmd_t;

  typedef struct packed {
    logic start_div;
  } dp_sts_t;

endpackage

// File: rtl/sdu_in_if.sv
// Input channel of the signed divide unit: one bus access per transfer.
// Depends on sdu_pkg.
interface sdu_in_if;
  import sdu_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  register_index;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, register_index, write_data, input ready);
  modport sink   (input valid, command, register_index, write_data, output ready);
endinterface

// File: rtl/sdu_out_if.sv
// Result channel of the signed divide unit: read data and flag per transfer.
// Depends on sdu_pkg.
interface sdu_out_if;
  import sdu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              overflow_flag;

  modport source (output valid, read_data, overflow_flag, input ready);
  modport sink   (input valid, read_data, overflow_flag, output ready);
endinterface

// File: rtl/sdu_ctrl.sv
// Controller of the signed divide unit: access sequencer FSM, iteration
// counter and result valid flag. Depends on sdu_pkg.
module sdu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sdu_pkg::dp_sts_t  sts_i,
  output sdu_pkg::dp_cmd_t  cmd_o
);
  import sdu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             push;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts_i.start_div ? S_DIVIDE : S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIVIDE: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd_o            = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      S_ACCESS: cmd_o.commit_reg = slot_free;
      S_DIVIDE: cmd_o.step = 1'b1;
      S_FINISH: cmd_o.commit_div = slot_free;
      default: cmd_o = '0;
    endcase
  end

  assign push = cmd_o.commit_reg || cmd_o.commit_div;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd_o.load) begin
      cnt_nxt = '0;
    end else if (cmd_o.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/sdu_dp.sv
// Datapath of the signed divide unit: register file, magnitude conversion,
// radix-4 restoring divide step, sign fixup and result register. Depends on sdu_pkg.
module sdu_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sdu_pkg::dp_cmd_t            cmd_i,
  output sdu_pkg::dp_sts_t            sts_o,
  input  logic                        in_command,
  input  logic [sdu_pkg::IDX_W-1:0]   in_index,
  input  logic [sdu_pkg::DATA_W-1:0]  in_wdata,
  output logic [sdu_pkg::DATA_W-1:0]  out_read_data,
  output logic                        out_overflow_flag
);
  import sdu_pkg::*;

  // architectural registers
  logic [DATA_W-1:0] divisor_r, divisor_nxt;
  logic [DATA_W-1:0] high_r, high_nxt;
  logic [DATA_W-1:0] low_r, low_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [VEC_W-1:0]  vector_r, vector_nxt;

  // pending access
  logic              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] data_r;

  // divider state
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DATA_W-1:0] bmag_r;
  logic              dvd_neg_r, q_neg_r;

  // result register
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic              flag_r, flag_nxt;

  logic [DATA_W-1:0] hi_w, bmag_w;
  logic [DVD_W-1:0]  dvd_w, dvd_mag_w;
  logic              dvd_neg_w, dvs_neg_w;

  logic [DATA_W:0]   t1, t2;
  logic              ge1, ge2;
  logic [DATA_W-1:0] r1;
  logic [DVD_W-1:0]  q1;

  logic              ovf_w;
  logic [DATA_W-1:0] q_res, r_res;
  logic [DATA_W-1:0] rd_w;

  // operand setup at transfer
  always_comb begin
    hi_w      = (in_index == IDX_SHORT) ? {DATA_W{in_wdata[DATA_W-1]}} : high_r;
    dvd_w     = {hi_w, in_wdata};
    dvd_neg_w = hi_w[DATA_W-1];
    dvs_neg_w = divisor_r[DATA_W-1];
    dvd_mag_w = dvd_neg_w ? (DVD_W'(0) - dvd_w) : dvd_w;
    bmag_w    = dvs_neg_w ? (DATA_W'(0) - divisor_r) : divisor_r;
    sts_o.start_div = (in_command == CMD_WRITE) &&
                      ((in_index == IDX_SHORT) || (in_index == IDX_LONG)) &&
                      (divisor_r != '0);
  end

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_r, quo_r[DVD_W-1]};
    ge1 = t1 >= {1'b0, bmag_r};
    r1  = ge1 ? DATA_W'(t1 - {1'b0, bmag_r}) : t1[DATA_W-1:0];
    q1  = {quo_r[DVD_W-2:0], ge1};
    t2  = {r1, q1[DVD_W-1]};
    ge2 = t2 >= {1'b0, bmag_r};
    rem_nxt = ge2 ? DATA_W'(t2 - {1'b0, bmag_r}) : t2[DATA_W-1:0];
    quo_nxt = {q1[DVD_W-2:0], ge2};
  end

  // sign fixup and overflow check
  always_comb begin
    if (q_neg_r) begin
      ovf_w = (quo_r[DVD_W-1:DATA_W] != '0) ||
              (quo_r[DATA_W-1] && (quo_r[DATA_W-2:0] != '0));
    end else begin
      ovf_w = quo_r[DVD_W-1:DATA_W-1] != '0;
    end
    q_res = q_neg_r ? (DATA_W'(0) - quo_r[DATA_W-1:0]) : quo_r[DATA_W-1:0];
    r_res = dvd_neg_r ? (DATA_W'(0) - rem_r) : rem_r;
  end

  always_comb begin
    case (idx_r)
      IDX_DIVISOR: rd_w = divisor_r;
      IDX_SHORT:   rd_w = low_r;
      IDX_CONTROL: rd_w = DATA_W'(ctrl_r);
      IDX_VECTOR:  rd_w = DATA_W'(vector_r);
      IDX_HIGH:    rd_w = high_r;
      IDX_LONG:    rd_w = low_r;
      default:     rd_w = '0;
    endcase
  end

  always_comb begin
    divisor_nxt = divisor_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    ctrl_nxt    = ctrl_r;
    vector_nxt  = vector_r;
    rd_nxt      = rd_r;
    flag_nxt    = flag_r;
    if (cmd_i.commit_reg) begin
      if (cmd_r == CMD_WRITE) begin
        // writes to either dividend here only see a zero divisor
        case (idx_r)
          IDX_DIVISOR: divisor_nxt = data_r;
          IDX_SHORT: begin
            low_nxt            = data_r;
            high_nxt           = {DATA_W{data_r[DATA_W-1]}};
            ctrl_nxt[FLAG_BIT] = 1'b1;
          end
          IDX_CONTROL: ctrl_nxt = data_r[CTRL_W-1:0];
          IDX_VECTOR:  vector_nxt = data_r[VEC_W-1:0];
          IDX_HIGH:    high_nxt = data_r;
          IDX_LONG: begin
            low_nxt            = data_r;
            ctrl_nxt[FLAG_BIT] = 1'b1;
          end
          default: ctrl_nxt = ctrl_r;
        endcase
        rd_nxt = '0;
      end else begin
        rd_nxt = rd_w;
      end
      flag_nxt = ctrl_nxt[FLAG_BIT];
    end else if (cmd_i.commit_div) begin
      low_nxt            = q_res;
      high_nxt           = r_res;
      ctrl_nxt[FLAG_BIT] = ovf_w;
      rd_nxt             = '0;
      flag_nxt           = ovf_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= '0;
      high_r    <= '0;
      low_r     <= '0;
      ctrl_r    <= '0;
      vector_r  <= '0;
    end else begin
      divisor_r <= divisor_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
      ctrl_r    <= ctrl_nxt;
      vector_r  <= vector_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r     <= in_command;
      idx_r     <= in_index;
      data_r    <= in_wdata;
      rem_r     <= '0;
      quo_r     <= dvd_mag_w;
      bmag_r    <= bmag_w;
      dvd_neg_r <= dvd_neg_w;
      q_neg_r   <= dvd_neg_w ^ dvs_neg_w;
    end else if (cmd_i.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    rd_r   <= rd_nxt;
    flag_r <= flag_nxt;
  end

  assign out_read_data     = rd_r;
  assign out_overflow_flag = flag_r;

endmodule

// File: rtl/signed_divide_unit_registers_top.sv
// Signed divide unit, top level. Reads and plain writes: the access is
// registered, then committed to the output register once it is free; next
// transfer taken after that commit. Dividend writes with a nonzero divisor:
// 64/32 restoring divide at two quotient bits per cycle, 32 iterations; result
// committed once the output register is free, next transfer taken after that.
// The output register holds a result while the next access is taken.
// Synchronous active-low reset clears all five registers; no clearing pass.
module signed_divide_unit_registers_top (
  input  logic  clk,
  input  logic  rst_n,
  sdu_in_if.sink    in_ch,
  sdu_out_if.source out_ch
);
  import sdu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sdu_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_command        (in_ch.command),
    .in_index          (in_ch.register_index),
    .in_wdata          (in_ch.write_data),
    .out_read_data     (out_ch.read_data),
    .out_overflow_flag (out_ch.overflow_flag)
  );

  a_load_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.step)
    else $error("transfer accepted during divide iteration");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit_reg && cmd.commit_div))
    else $error("register and divide commit together");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit_reg || cmd.commit_div) |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending transfer");

  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.start_div) |=> cmd.step)
    else $error("divide did not start after dividend write");

endmodule
